### rtl/core/apf_pkg.sv
// ----------------------------------------------------------------------------
// apf_pkg
// Shared types and constants of the amicable pair finder: controller states,
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package apf_pkg;

    // Width of a stored divisor sum; sums clip at the all-ones value.
    localparam int SUM_W = 17;
    // Width of the result number fields.
    localparam int NUM_W = 15;
    // Width of the limit field.
    localparam int LIMIT_W = 15;
    // Most pairs reported by one search.
    localparam int MAX_PAIRS = 8;
    localparam int PAIR_CNT_W = $clog2(MAX_PAIRS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_INIT,
        ST_SUM_RD,
        ST_SUM_WR,
        ST_SCAN_RDA,
        ST_SCAN_CHKA,
        ST_SCAN_CHKB,
        ST_EMIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;        // capture a new limit
        logic init_wr;     // first pass: write one at m
        logic sum_rd;      // read the table at m
        logic sum_wr;      // write the updated sum at m
        logic step_m;      // m <= m + d
        logic next_d;      // d <= d + 1, m <= 2 * (d + 1)
        logic start_scan;  // a <= 2
        logic rd_b;        // read the table at the partner, keep the partner
        logic step_a;      // a <= a + 1
        logic emit;        // push a found pair into the pending slot
        logic finish;      // send the closing result
    } cmd_t;

    typedef struct packed {
        logic lim_small;   // limit below two
        logic m_over;      // m + d passes the limit
        logic d_over;      // 2 * (d + 1) passes the limit
        logic a_last;      // a equals the limit
        logic cand;        // partner lies above a and within the limit
        logic match;       // partner's sum equals a
        logic out_free;    // output register can take a result
        logic pend_valid;  // a pair waits in the pending slot
        logic count_full;  // this pair fills the last result slot
    } status_t;

endpackage

`default_nettype wire

### rtl/core/apf_ram.sv
// ----------------------------------------------------------------------------
// apf_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module apf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16385
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/apf_ctrl.sv
// ----------------------------------------------------------------------------
// apf_ctrl
// Controller of the amicable pair finder: sequences the divisor-sum sieve,
// the table scan and the delivery of results.
// ----------------------------------------------------------------------------
`default_nettype none

module apf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  apf_pkg::status_t      status,
    output apf_pkg::cmd_t         cmd
);

    apf_pkg::state_t state_reg;
    apf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= apf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            apf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = apf_pkg::ST_START;
                end
            end
            apf_pkg::ST_START:
            begin
                state_next = status.lim_small ? apf_pkg::ST_FINISH : apf_pkg::ST_INIT;
            end
            apf_pkg::ST_INIT:
            begin
                if (status.m_over)
                begin
                    state_next = status.d_over ? apf_pkg::ST_SCAN_RDA : apf_pkg::ST_SUM_RD;
                end
            end
            apf_pkg::ST_SUM_RD:
            begin
                state_next = apf_pkg::ST_SUM_WR;
            end
            apf_pkg::ST_SUM_WR:
            begin
                if (status.m_over && status.d_over)
                begin
                    state_next = apf_pkg::ST_SCAN_RDA;
                end
                else
                begin
                    state_next = apf_pkg::ST_SUM_RD;
                end
            end
            apf_pkg::ST_SCAN_RDA:
            begin
                state_next = apf_pkg::ST_SCAN_CHKA;
            end
            apf_pkg::ST_SCAN_CHKA:
            begin
                if (status.cand)
                begin
                    state_next = apf_pkg::ST_SCAN_CHKB;
                end
                else
                begin
                    state_next = status.a_last ? apf_pkg::ST_FINISH : apf_pkg::ST_SCAN_RDA;
                end
            end
            apf_pkg::ST_SCAN_CHKB:
            begin
                if (status.match)
                begin
                    state_next = apf_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = status.a_last ? apf_pkg::ST_FINISH : apf_pkg::ST_SCAN_RDA;
                end
            end
            apf_pkg::ST_EMIT:
            begin
                if (!status.pend_valid || status.out_free)
                begin
                    if (status.count_full || status.a_last)
                    begin
                        state_next = apf_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = apf_pkg::ST_SCAN_RDA;
                    end
                end
            end
            apf_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = apf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = apf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            apf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            apf_pkg::ST_INIT:
            begin
                cmd.init_wr    = 1'b1;
                cmd.step_m     = !status.m_over;
                cmd.next_d     = status.m_over;
                cmd.start_scan = status.m_over && status.d_over;
            end
            apf_pkg::ST_SUM_RD:
            begin
                cmd.sum_rd = 1'b1;
            end
            apf_pkg::ST_SUM_WR:
            begin
                cmd.sum_wr     = 1'b1;
                cmd.step_m     = !status.m_over;
                cmd.next_d     = status.m_over;
                cmd.start_scan = status.m_over && status.d_over;
            end
            apf_pkg::ST_SCAN_CHKA:
            begin
                cmd.rd_b   = 1'b1;
                cmd.step_a = !status.cand && !status.a_last;
            end
            apf_pkg::ST_SCAN_CHKB:
            begin
                cmd.step_a = !status.match && !status.a_last;
            end
            apf_pkg::ST_EMIT:
            begin
                if (!status.pend_valid || status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.step_a = !status.count_full && !status.a_last;
                end
            end
            apf_pkg::ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/apf_dp.sv
// ----------------------------------------------------------------------------
// apf_dp
// Datapath of the amicable pair finder: the divisor-sum table, the sieve and
// scan counters, the pending pair and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module apf_dp #(
    parameter int MAX_LIMIT = 16384
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [apf_pkg::LIMIT_W-1:0]   limit,
    input  wire logic                          out_stall,
    input  apf_pkg::cmd_t                      cmd,
    output apf_pkg::status_t                   status,
    output logic                               out_valid,
    output logic      [apf_pkg::NUM_W-1:0]     smaller,
    output logic      [apf_pkg::NUM_W-1:0]     larger,
    output logic                               pair_valid,
    output logic                               last
);

    localparam int DEPTH  = MAX_LIMIT + 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CW     = IDX_W + 1;
    localparam int SUM_W  = apf_pkg::SUM_W;
    localparam int SUM_XW = SUM_W + 1;
    localparam int NUM_W  = apf_pkg::NUM_W;
    localparam int PCW    = apf_pkg::PAIR_CNT_W;

    logic [IDX_W-1:0] lim_reg;
    logic [CW-1:0]    d_reg;
    logic [CW-1:0]    m_reg;
    logic [IDX_W-1:0] a_reg;
    logic [IDX_W-1:0] b_reg;
    logic [PCW-1:0]   count_reg;
    logic             pend_valid_reg;
    logic [NUM_W-1:0] pend_a_reg;
    logic [NUM_W-1:0] pend_b_reg;
    logic             out_valid_reg;
    logic [NUM_W-1:0] smaller_reg;
    logic [NUM_W-1:0] larger_reg;
    logic             pair_valid_reg;
    logic             last_reg;

    logic [IDX_W-1:0] lim_next;
    logic             lim_sat;
    logic [CW-1:0]    m_step;
    logic [CW-1:0]    d_inc;
    logic [CW-1:0]    m_first;
    logic [SUM_XW-1:0] sum_add;
    logic [SUM_W-1:0] sum_sat;
    logic             out_free;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [SUM_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [SUM_W-1:0] ram_rdata;

    apf_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign lim_sat  = 32'(limit) > 32'(MAX_LIMIT);
    assign lim_next = lim_sat ? IDX_W'(MAX_LIMIT) : IDX_W'(limit);

    assign m_step  = m_reg + d_reg;
    assign d_inc   = d_reg + CW'(1);
    assign m_first = {d_inc[CW-2:0], 1'b0};

    // Every sum gets the divisor one in the first pass, so that pass writes
    // without reading and no separate clearing of the table is needed.
    assign sum_add = {1'b0, ram_rdata} + SUM_XW'(d_reg);
    assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

    assign ram_we    = cmd.init_wr || cmd.sum_wr;
    assign ram_waddr = m_reg[IDX_W-1:0];
    assign ram_wdata = cmd.init_wr ? SUM_W'(1) : sum_sat;
    assign ram_raddr = cmd.rd_b   ? IDX_W'(ram_rdata) :
                       cmd.sum_rd ? m_reg[IDX_W-1:0]  : a_reg;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        status            = '0;
        status.lim_small  = lim_reg < IDX_W'(2);
        status.m_over     = m_step > {1'b0, lim_reg};
        status.d_over     = m_first > {1'b0, lim_reg};
        status.a_last     = a_reg == lim_reg;
        status.cand       = (32'(ram_rdata) > 32'(a_reg)) && (32'(ram_rdata) <= 32'(lim_reg));
        status.match      = 32'(ram_rdata) == 32'(a_reg);
        status.out_free   = out_free;
        status.pend_valid = pend_valid_reg;
        status.count_full = count_reg == PCW'(apf_pkg::MAX_PAIRS - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg        <= '0;
            d_reg          <= '0;
            m_reg          <= '0;
            a_reg          <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                lim_reg        <= lim_next;
                d_reg          <= CW'(1);
                m_reg          <= CW'(2);
                count_reg      <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.step_m)
            begin
                m_reg <= m_step;
            end
            if (cmd.next_d)
            begin
                d_reg <= d_inc;
                m_reg <= m_first;
            end
            if (cmd.start_scan)
            begin
                a_reg <= IDX_W'(2);
            end
            if (cmd.step_a)
            begin
                a_reg <= a_reg + IDX_W'(1);
            end
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
                count_reg      <= count_reg + PCW'(1);
            end
            if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end

            if ((cmd.emit && pend_valid_reg) || cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_b)
        begin
            b_reg <= IDX_W'(ram_rdata);
        end
        if (cmd.emit)
        begin
            pend_a_reg <= NUM_W'(a_reg);
            pend_b_reg <= NUM_W'(b_reg);
        end
        // A new pair pushes the previous one out; the last pair of a search
        // is only known once the scan is over.
        if (cmd.emit && pend_valid_reg)
        begin
            smaller_reg    <= pend_a_reg;
            larger_reg     <= pend_b_reg;
            pair_valid_reg <= 1'b1;
            last_reg       <= 1'b0;
        end
        else if (cmd.finish)
        begin
            smaller_reg    <= pend_valid_reg ? pend_a_reg : '0;
            larger_reg     <= pend_valid_reg ? pend_b_reg : '0;
            pair_valid_reg <= pend_valid_reg;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign smaller    = smaller_reg;
    assign larger     = larger_reg;
    assign pair_valid = pair_valid_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

### rtl/core/amicable_pair_finder.sv
// ----------------------------------------------------------------------------
// amicable_pair_finder
// Searches the numbers up to a given limit for amicable pairs, using a table
// of divisor sums built by a sieve, and reports up to eight pairs in ascending order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  -------   ---------  --------------------  ------------------------------------
//  request   in         in_valid / in_stall   limit
//  result    out        out_valid / out_stall smaller, larger, pair_valid, last
//
// The sieve does a read and a write of the single table RAM for each divisor
// update after a first pass that only writes, then the scan checks each number
// in turn, reading the table at the number and, for a candidate, at its partner.
// Only one request is in work at a time; in_stall is low only while idle.
// A stalled result holds the output register and pauses the scan when a new
// pair finds it full. Reset clears all control state; the table needs none.
//
`default_nettype none

module amicable_pair_finder #(
    parameter int MAX_LIMIT = 16384
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [apf_pkg::LIMIT_W-1:0] limit,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [apf_pkg::NUM_W-1:0]   smaller,
    output logic      [apf_pkg::NUM_W-1:0]   larger,
    output logic                             pair_valid,
    output logic                             last
);

    apf_pkg::cmd_t    cmd;
    apf_pkg::status_t status;

    apf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    apf_dp #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .limit      (limit),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .smaller    (smaller),
        .larger     (larger),
        .pair_valid (pair_valid),
        .last       (last)
    );

endmodule

`default_nettype wire
